### sv/stos_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stos_pkg
// Shared types and constants of the spanning tree offset solver.
// ----------------------------------------------------------------------------
package stos_pkg;

  localparam int MAX_SOURCES_DEF = 16;

  localparam int IDX_W   = 4;   // source index field width
  localparam int CORR_W  = 32;
  localparam int PTIME_W = 32;
  localparam int INIT_W  = 40;
  localparam int FRM_W   = 20;
  localparam int FLEN_W  = 32;
  localparam int NSRC_W  = 5;
  localparam int TIME_W  = 48;  // signed absolute time
  localparam int NUM_W   = TIME_W + 8;

  localparam logic [FRM_W-1:0] FRAME_SAT = 20'hFFFFF;

  localparam logic [NSRC_W-1:0] NSRC_RST = 5'd2;
  localparam logic [FLEN_W-1:0] FLEN_RST = 32'd8533248;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    FUNC_LOAD_PAIR = 2'd0,
    FUNC_LOAD_INIT = 2'd1,
    FUNC_START     = 2'd2,
    FUNC_NONE      = 2'd3
  } func_t;

  typedef enum logic {
    REG_N_SOURCES = 1'b0,
    REG_FRAME_LEN = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PICK,
    S_MARK,
    S_RELAX_RD,
    S_RELAX_CMP,
    S_TM_PAR,
    S_TM_RD,
    S_TM_ADD,
    S_MX_RD,
    S_MX_CMP,
    S_PRE_RD,
    S_PRE_CMP,
    S_OUT_DIV,
    S_OUT_WAIT,
    S_OUT_SEND
  } state_t;

endpackage : stos_pkg
`default_nettype wire

### sv/spanning_tree_offset_solver_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spanning_tree_offset_solver_core
// Maximum spanning tree over source correlations, then per-source frame
// offsets.
// ----------------------------------------------------------------------------
// Load words (pair entries, initial offsets) are taken one per cycle while
// idle. A start word runs a sequencer over N sources with one compare/add
// unit and one-read memories: N pick scans, N-1 relax passes, time
// propagation, two passes for the maxima, then per source a 56-step serial
// divide and the wait on the result port. No word is accepted until the last
// result word of a start has been taken.
module spanning_tree_offset_solver_core #(
  parameter int MAX_SOURCES = stos_pkg::MAX_SOURCES_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  // fields: src_a, src_b, corr, pair_time, init_offset
  input  wire  [stos_pkg::IN_DATA_W-1:0]      s_tdata,
  // fields: func
  input  wire  [1:0]                          s_tuser,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  // fields: source_index, frames
  output logic [stos_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                m_tlast,
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  input  wire                                 cfg_we,
  input  wire                                 cfg_index,
  input  wire  [stos_pkg::FLEN_W-1:0]         cfg_data
);

  localparam int SW = $clog2(MAX_SOURCES);
  localparam int CW = $clog2(MAX_SOURCES + 1);
  localparam int AW = 2 * SW;
  localparam int TW = stos_pkg::TIME_W;

  stos_pkg::state_t state, state_next;

  logic [stos_pkg::NSRC_W-1:0] n_sources;
  logic [stos_pkg::FLEN_W-1:0] frame_len;

  logic [stos_pkg::CORR_W-1:0]  corr_mem [2**AW];
  logic [stos_pkg::PTIME_W-1:0] time_mem [2**AW];
  logic [stos_pkg::INIT_W-1:0]  init_mem [MAX_SOURCES];
  logic [stos_pkg::CORR_W-1:0]  corr_q;
  logic [stos_pkg::PTIME_W-1:0] time_q;
  logic [stos_pkg::INIT_W-1:0]  init_q;

  logic [SW-1:0]               parent_of [MAX_SOURCES];
  logic [stos_pkg::CORR_W-1:0] best_key  [MAX_SOURCES];
  logic                        in_tree   [MAX_SOURCES];
  logic signed [TW-1:0]        abs_time  [MAX_SOURCES];
  logic [SW-1:0]               order     [MAX_SOURCES];

  logic [CW-1:0]               n_r;
  logic [CW-1:0]               nm1;
  logic [CW-1:0]               cnt;
  logic [CW-1:0]               pk;
  logic [SW-1:0]               pick;
  logic                        have;
  logic [stos_pkg::CORR_W-1:0] pbk;
  logic [SW-1:0]               jr;
  logic [SW-1:0]               pr;
  logic signed [TW-1:0]        absp;
  logic signed [TW-1:0]        mx;
  logic [stos_pkg::INIT_W-1:0] maxinit;
  logic signed [TW-1:0]        peak;

  logic                        s_fire;
  logic [1:0]                  func;
  logic [stos_pkg::IDX_W-1:0]  src_a;
  logic [stos_pkg::IDX_W-1:0]  src_b;
  logic                        a_ok;
  logic                        b_ok;
  logic [CW-1:0]               n_eff;
  logic [SW-1:0]               idx;
  logic                        last_idx;
  logic [AW-1:0]               corr_ra;
  logic [AW-1:0]               time_ra;
  logic [SW-1:0]               abs_ra;
  logic signed [TW-1:0]        abs_rd;
  logic signed [TW-1:0]        tm_sum;
  logic signed [TW-1:0]        pre;
  logic signed [TW-1:0]        tdist;
  logic                        div_start;
  logic                        div_done;
  logic [stos_pkg::FRM_W-1:0]  div_frame;

  assign func     = s_tuser;
  assign src_a    = s_tdata[3:0];
  assign src_b    = s_tdata[7:4];
  assign s_tready = (state == stos_pkg::S_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign a_ok     = (32'(src_a) < MAX_SOURCES);
  assign b_ok     = (32'(src_b) < MAX_SOURCES);
  assign nm1      = n_r - CW'(1);
  assign idx      = cnt[SW-1:0];
  assign last_idx = (cnt == nm1);

  always_comb begin
    if (n_sources < 5'd2) begin
      n_eff = CW'(2);
    end else if (32'(n_sources) > MAX_SOURCES) begin
      n_eff = CW'(MAX_SOURCES);
    end else begin
      n_eff = CW'(n_sources);
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      n_sources <= stos_pkg::NSRC_RST;
      frame_len <= stos_pkg::FLEN_RST;
    end else if (cfg_we) begin
      case (stos_pkg::reg_idx_t'(cfg_index))
        stos_pkg::REG_N_SOURCES: n_sources <= cfg_data[stos_pkg::NSRC_W-1:0];
        stos_pkg::REG_FRAME_LEN: frame_len <= cfg_data;
        default: ;
      endcase
    end
  end

  // memories
  assign corr_ra = {pick, idx};
  assign time_ra = {pr, jr};

  always_ff @(posedge clk) begin
    if (s_fire && func == stos_pkg::FUNC_LOAD_PAIR && a_ok && b_ok) begin
      corr_mem[{SW'(src_a), SW'(src_b)}] <= s_tdata[39:8];
      time_mem[{SW'(src_a), SW'(src_b)}] <= s_tdata[71:40];
    end
    if (s_fire && func == stos_pkg::FUNC_LOAD_INIT && a_ok) begin
      init_mem[SW'(src_a)] <= s_tdata[111:72];
    end
    corr_q <= corr_mem[corr_ra];
    time_q <= time_mem[time_ra];
    init_q <= init_mem[idx];
  end

  always_comb begin
    case (state)
      stos_pkg::S_TM_RD: abs_ra = pr;
      default:           abs_ra = idx;
    endcase
  end

  assign abs_rd = abs_time[abs_ra];
  assign tm_sum = absp + {{(TW-stos_pkg::PTIME_W){time_q[stos_pkg::PTIME_W-1]}}, time_q};
  assign pre    = ($signed({{(TW-stos_pkg::INIT_W){1'b0}}, maxinit})
                   - $signed({{(TW-stos_pkg::INIT_W){1'b0}}, init_q}))
                  - (mx - abs_rd);
  assign tdist  = peak - abs_rd;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stos_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      stos_pkg::S_IDLE: begin
        if (s_fire && func == stos_pkg::FUNC_START) begin
          state_next = stos_pkg::S_PICK;
        end
      end
      stos_pkg::S_PICK: begin
        if (last_idx) state_next = stos_pkg::S_MARK;
      end
      stos_pkg::S_MARK: begin
        state_next = (pk == nm1) ? stos_pkg::S_TM_PAR : stos_pkg::S_RELAX_RD;
      end
      stos_pkg::S_RELAX_RD:  state_next = stos_pkg::S_RELAX_CMP;
      stos_pkg::S_RELAX_CMP: begin
        state_next = last_idx ? stos_pkg::S_PICK : stos_pkg::S_RELAX_RD;
      end
      stos_pkg::S_TM_PAR: state_next = stos_pkg::S_TM_RD;
      stos_pkg::S_TM_RD:  state_next = stos_pkg::S_TM_ADD;
      stos_pkg::S_TM_ADD: begin
        state_next = last_idx ? stos_pkg::S_MX_RD : stos_pkg::S_TM_PAR;
      end
      stos_pkg::S_MX_RD:  state_next = stos_pkg::S_MX_CMP;
      stos_pkg::S_MX_CMP: begin
        state_next = last_idx ? stos_pkg::S_PRE_RD : stos_pkg::S_MX_RD;
      end
      stos_pkg::S_PRE_RD:  state_next = stos_pkg::S_PRE_CMP;
      stos_pkg::S_PRE_CMP: begin
        state_next = last_idx ? stos_pkg::S_OUT_DIV : stos_pkg::S_PRE_RD;
      end
      stos_pkg::S_OUT_DIV: begin
        div_start  = 1'b1;
        state_next = stos_pkg::S_OUT_WAIT;
      end
      stos_pkg::S_OUT_WAIT: begin
        if (div_done) state_next = stos_pkg::S_OUT_SEND;
      end
      stos_pkg::S_OUT_SEND: begin
        if (m_tready) begin
          state_next = last_idx ? stos_pkg::S_IDLE : stos_pkg::S_OUT_DIV;
        end
      end
      default: state_next = stos_pkg::S_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        stos_pkg::S_IDLE: begin
          if (s_fire && func == stos_pkg::FUNC_START) begin
            for (int k = 0; k < MAX_SOURCES; k++) begin
              best_key[k]  <= '0;
              in_tree[k]   <= 1'b0;
              parent_of[k] <= '0;
              abs_time[k]  <= '0;
            end
            n_r  <= n_eff;
            cnt  <= '0;
            pk   <= '0;
            have <= 1'b0;
          end
        end
        stos_pkg::S_PICK: begin
          // lowest index wins ties
          if (!in_tree[idx] && (!have || best_key[idx] > pbk)) begin
            pick <= idx;
            pbk  <= best_key[idx];
            have <= 1'b1;
          end
          cnt <= cnt + CW'(1);
        end
        stos_pkg::S_MARK: begin
          in_tree[pick]     <= 1'b1;
          order[pk[SW-1:0]] <= pick;
          pk                <= pk + CW'(1);
          have              <= 1'b0;
          if (pk == nm1) begin
            cnt <= CW'(1);
            mx  <= '0;
          end else begin
            cnt <= '0;
          end
        end
        stos_pkg::S_RELAX_CMP: begin
          if (!in_tree[idx] && corr_q > best_key[idx]) begin
            best_key[idx]  <= corr_q;
            parent_of[idx] <= pick;
          end
          cnt <= last_idx ? '0 : cnt + CW'(1);
        end
        stos_pkg::S_TM_PAR: begin
          jr <= order[idx];
          pr <= parent_of[order[idx]];
        end
        stos_pkg::S_TM_RD: begin
          absp <= abs_rd;
        end
        stos_pkg::S_TM_ADD: begin
          abs_time[jr] <= tm_sum;
          if (tm_sum > mx) mx <= tm_sum;
          if (last_idx) begin
            cnt     <= '0;
            maxinit <= '0;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        stos_pkg::S_MX_CMP: begin
          if (init_q > maxinit) maxinit <= init_q;
          if (last_idx) begin
            cnt  <= '0;
            peak <= '0;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        stos_pkg::S_PRE_CMP: begin
          // the time slot now holds the combined value
          abs_time[idx] <= pre;
          if (pre > peak) peak <= pre;
          cnt <= last_idx ? '0 : cnt + CW'(1);
        end
        stos_pkg::S_OUT_WAIT: begin
          if (div_done) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {div_frame, stos_pkg::IDX_W'(cnt)};
            m_tlast  <= last_idx;
          end
        end
        stos_pkg::S_OUT_SEND: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            cnt      <= cnt + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  stos_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({tdist, 8'h00}),
    .den   (frame_len),
    .done  (div_done),
    .frame (div_frame)
  );

endmodule : spanning_tree_offset_solver_core
`default_nettype wire

### sv/stos_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stos_div
// Bit-serial restoring divider with round half to even and saturation
// to a frame count.
// ----------------------------------------------------------------------------
module stos_div (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  input  wire  [stos_pkg::NUM_W-1:0]       num,
  input  wire  [stos_pkg::FLEN_W-1:0]      den,
  output logic                             done,
  output logic [stos_pkg::FRM_W-1:0]       frame
);

  localparam int NW = stos_pkg::NUM_W;
  localparam int DW = stos_pkg::FLEN_W;
  localparam int KW = $clog2(NW + 1);

  logic          busy;
  logic          fin;
  logic [KW-1:0] steps;
  logic [DW-1:0] dv;
  logic [DW-1:0] rem;
  logic [NW-1:0] nsh;
  logic [NW-1:0] quo;

  logic [DW:0]   r2;
  logic          ge;
  logic [DW:0]   r2_sub;
  logic          rnd_up;
  logic [NW:0]   q_rnd;

  assign r2     = {rem, nsh[NW-1]};
  assign ge     = (r2 >= {1'b0, dv});
  assign r2_sub = r2 - {1'b0, dv};
  // halfway goes to the even quotient
  assign rnd_up = ({rem, 1'b0} > {1'b0, dv}) || (({rem, 1'b0} == {1'b0, dv}) && quo[0]);
  assign q_rnd  = {1'b0, quo} + (NW+1)'(rnd_up);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= KW'(NW);
        rem   <= '0;
        nsh   <= num;
        quo   <= '0;
        dv    <= (den == '0) ? DW'(1) : den;
      end else if (busy) begin
        rem   <= ge ? r2_sub[DW-1:0] : r2[DW-1:0];
        quo   <= {quo[NW-2:0], ge};
        nsh   <= {nsh[NW-2:0], 1'b0};
        steps <= steps - KW'(1);
        if (steps == KW'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
      if (fin) begin
        fin   <= 1'b0;
        done  <= 1'b1;
        frame <= (q_rnd > (NW+1)'(stos_pkg::FRAME_SAT)) ? stos_pkg::FRAME_SAT
                                                        : q_rnd[stos_pkg::FRM_W-1:0];
      end
    end
  end

endmodule : stos_div
`default_nettype wire

### sv/stos_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stos_chk
// Port-level checks of the offset solver, bound to the top level.
// ----------------------------------------------------------------------------
module stos_chk (
  input wire                              clk,
  input wire                              rst,
  input wire                              s_tready,
  input wire [stos_pkg::OUT_DATA_W-1:0]   m_tdata,
  input wire                              m_tlast,
  input wire                              m_tvalid,
  input wire                              m_tready
);

  // a held result word keeps its data
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result word changed while stalled");

  // no input is taken while results are being delivered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready during result delivery");

  // the final word of a run is followed by a gap
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
    else $error("result after final word");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule : stos_chk

bind spanning_tree_offset_solver_core stos_chk u_stos_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
`default_nettype wire
